>>> rtl/lane_line_selector_defines.svh
// Assertion macros for the checker file of the lane line selector.
// Holds macro definitions only.
`ifndef LANE_LINE_SELECTOR_DEFINES_SVH
`define LANE_LINE_SELECTOR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LLS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lls check failed");

// Next-cycle implication checked outside reset.
`define LLS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lls check failed");

`endif

>>> rtl/lls_pkg.sv
// Package for the lane line selector: sine, cosine and angle score tables,
// register indexes and the queue entry type. Used by every module of the block.
`timescale 1ns / 1ps
package lls_pkg;

  localparam int TrigFracBits = 14;
  localparam int AngleSteps   = 180;
  localparam int QuarterSteps = AngleSteps / 2;

  localparam logic [2:0] RegSideMode   = 3'd0;
  localparam logic [2:0] RegTopRow     = 3'd1;
  localparam logic [2:0] RegBottomRow  = 3'd2;
  localparam logic [2:0] RegLeftBound  = 3'd3;
  localparam logic [2:0] RegRightBound = 3'd4;

  localparam longint unsigned SinDens [6] = '{156, 110, 72, 42, 20, 6};
  localparam longint unsigned CosDens [7] = '{182, 132, 90, 56, 30, 12, 2};

  typedef struct packed {
    logic               plane;
    logic               last;
    logic signed [11:0] rho;
    logic [7:0]         theta;
    logic               upper;
    logic [15:0]        sin_q;
    logic [15:0]        cos_q;
    logic [10:0]        th8;
  } lls_item_t;

  // Q30 angle, sin and cos Taylor series, rounded to TrigFracBits bits.
  function automatic logic [63:0] lls_trig(input int tr, input bit want_sin);
    longint unsigned x, x2, r, t, pi30, one;
    pi30 = 64'd3373259426;
    one = 64'd1073741824;
    x = (longint'(tr) * pi30 + AngleSteps / 2) / AngleSteps;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    r = one;
    if (want_sin) begin
      for (int i = 0; i < 6; i++) begin
        t = ((x2 * r) >> 30) / SinDens[i];
        r = (t > one) ? 0 : one - t;
      end
      r = (x * r) >> 30;
    end else begin
      for (int i = 0; i < 7; i++) begin
        t = ((x2 * r) >> 30) / CosDens[i];
        r = (t > one) ? 0 : one - t;
      end
    end
    return (r + (64'd1 << (29 - TrigFracBits))) >> (30 - TrigFracBits);
  endfunction

  typedef logic [15:0] lls_rom_t [0:QuarterSteps];

  function automatic lls_rom_t lls_mk(input bit want_sin);
    lls_rom_t m;
    for (int i = 0; i <= QuarterSteps; i++) begin
      m[i] = 16'(lls_trig(i, want_sin));
    end
    return m;
  endfunction

  localparam lls_rom_t lls_trig_rom_s = lls_mk(1'b1);
  localparam lls_rom_t lls_trig_rom_c = lls_mk(1'b0);

  function automatic logic [15:0] lls_sin(input logic [6:0] tr);
    return lls_trig_rom_s[tr];
  endfunction

  function automatic logic [15:0] lls_cos(input logic [6:0] tr);
    return lls_trig_rom_c[tr];
  endfunction

  // Angle in radians, Q8, rounded.
  function automatic logic [10:0] lls_th8_calc(input int t);
    longint unsigned th30;
    th30 = (longint'(t) * 64'd3373259426 + AngleSteps / 2) / AngleSteps;
    return 11'((th30 + (64'd1 << 21)) >> 22);
  endfunction

  typedef logic [10:0] lls_th_rom_t [0:AngleSteps-1];

  function automatic lls_th_rom_t lls_mk_th8();
    lls_th_rom_t m;
    for (int i = 0; i < AngleSteps; i++) begin
      m[i] = lls_th8_calc(i);
    end
    return m;
  endfunction

  localparam lls_th_rom_t lls_th8_rom = lls_mk_th8();

  function automatic logic [10:0] lls_th8(input logic [7:0] t);
    return (t < 8'(AngleSteps)) ? lls_th8_rom[t] : 11'd0;
  endfunction

endpackage

>>> rtl/lls_front.sv
// Front part: accepts lines, checks the half-plane and looks up sin, cos and
// the angle term. Depends on lls_pkg.
`timescale 1ns / 1ps
module lls_front
  import lls_pkg::*;
(
  input  logic               side_mode,
  input  logic               in_valid,
  input  logic signed [11:0] in_line_rho,
  input  logic [7:0]         in_line_theta_deg,
  input  logic               in_last_line,
  output logic               item_valid,
  output lls_item_t          item
);

  logic       upper;
  logic       plane;
  logic [6:0] tr;

  always_comb begin
    upper = {1'b0, in_line_theta_deg, 1'b0} > 10'(AngleSteps);
    if (side_mode == 1'b0) begin
      plane = (in_line_theta_deg != 8'd0) &&
              ({1'b0, in_line_theta_deg, 1'b0} < 10'(AngleSteps));
    end else begin
      plane = upper && (in_line_theta_deg < 8'(AngleSteps));
    end
    tr = upper ? 7'(8'(AngleSteps) - in_line_theta_deg) : in_line_theta_deg[6:0];
    if (!plane) begin
      tr = 7'd0;
    end
  end

  always_comb begin
    item_valid  = in_valid;
    item.plane  = plane;
    item.last   = in_last_line;
    item.rho    = in_line_rho;
    item.theta  = in_line_theta_deg;
    item.upper  = upper;
    item.sin_q  = lls_sin(tr);
    item.cos_q  = lls_cos(tr);
    item.th8    = lls_th8(in_line_theta_deg);
  end

endmodule

>>> rtl/lls_queue.sv
// Two-entry queue between the front and back parts.
// Depends on lls_pkg for the entry type.
`timescale 1ns / 1ps
module lls_queue
  import lls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_stall,
  input  lls_item_t wr_data,
  output logic      rd_valid,
  input  logic      rd_take,
  output lls_item_t rd_data
);

  lls_item_t mem_r [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_stall = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && !wr_stall) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && !wr_stall) begin
        wp_r <= ~wp_r;
      end
      if (rd_take) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(wr_valid && !wr_stall) - 2'(rd_take);
    end
  end

endmodule

>>> rtl/lls_back.sv
// Back part: divides for both crossings, checks margins, scores and keeps the
// best line, and gives the frame result. Depends on lls_pkg.
`timescale 1ns / 1ps
module lls_back
  import lls_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               side_mode,
  input  logic [11:0]        top_row,
  input  logic [11:0]        bottom_row,
  input  logic [11:0]        left_bound,
  input  logic [11:0]        right_bound,
  input  logic               q_valid,
  input  lls_item_t          q_data,
  output logic               q_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_lane_found,
  output logic signed [15:0] out_lane_bottom_x,
  output logic signed [15:0] out_lane_top_x,
  output logic [7:0]         out_lane_theta_deg,
  output logic signed [11:0] out_lane_rho
);

  localparam int NumW = 40;
  localparam int DenW = 16;

  typedef enum logic [2:0] {S_IDLE, S_DIVB, S_DIVT, S_EVAL, S_OUT} state_t;

  state_t              state_r;
  lls_item_t           it_r;
  logic [5:0]          cnt_r;
  logic [NumW-1:0]     rem_r, quo_r, num_top_r;
  logic                neg_b_r, neg_t_r;
  logic signed [NumW:0] bx_r, tx_r;
  logic signed [31:0]  best_score_r;
  logic signed [15:0]  best_bottom_r, best_top_r;
  logic [7:0]          best_angle_r;
  logic signed [11:0]  best_rho_r;
  logic                have_best_r;

  logic [27:0]          prod_b, prod_t;
  logic signed [NumW:0] nb, nt;
  logic [NumW-1:0]      rem_sh;
  logic [NumW:0]        trial;
  logic                 pass;
  logic signed [NumW+1:0] score_w;

  function automatic logic signed [15:0] sat16(input logic signed [NumW:0] v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    prod_b = bottom_row * q_data.sin_q;
    prod_t = top_row * q_data.sin_q;
    nb = (NumW+1)'($signed({q_data.rho, {TrigFracBits{1'b0}}}))
         - $signed({13'd0, prod_b});
    nt = (NumW+1)'($signed({q_data.rho, {TrigFracBits{1'b0}}}))
         - $signed({13'd0, prod_t});
    rem_sh = {rem_r[NumW-2:0], quo_r[NumW-1]};
    trial  = {1'b0, rem_sh} - (NumW+1)'(it_r.cos_q);
    pass = (bx_r < $signed({29'd0, right_bound})) &&
           (tx_r < $signed({29'd0, right_bound})) &&
           (bx_r > $signed({29'd0, left_bound}));
    if (side_mode) begin
      pass = pass && (tx_r > $signed({29'd0, left_bound}));
    end
    score_w = -(NumW+2)'(10) * $signed({31'd0, it_r.th8})
              - (NumW+2)'(512) * ($signed({30'd0, right_bound}) - (NumW+2)'(bx_r));
  end

  assign q_take = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid    <= 1'b0;
      have_best_r  <= 1'b0;
      best_score_r <= 32'sh80000000;
      best_bottom_r <= '0;
      best_top_r   <= '0;
      best_angle_r <= '0;
      best_rho_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r <= q_data;
            neg_b_r <= nb[NumW];
            neg_t_r <= nt[NumW];
            quo_r <= nb[NumW] ? NumW'(-nb) : NumW'(nb);
            num_top_r <= nt[NumW] ? NumW'(-nt) : NumW'(nt);
            rem_r <= '0;
            cnt_r <= 6'(NumW);
            state_r <= (q_data.plane && q_data.cos_q != 16'd0) ? S_DIVB :
                       (q_data.last ? S_OUT : S_IDLE);
          end
        end
        S_DIVB, S_DIVT: begin
          if (cnt_r == 6'd1) begin
            if (state_r == S_DIVB) begin
              bx_r <= ((neg_b_r ^ it_r.upper) ?
                       -$signed({1'b0, quo_r[NumW-2:0], ~trial[NumW]}) :
                       $signed({1'b0, quo_r[NumW-2:0], ~trial[NumW]}));
              quo_r <= num_top_r;
              rem_r <= '0;
              cnt_r <= 6'(NumW);
              state_r <= S_DIVT;
            end else begin
              tx_r <= ((neg_t_r ^ it_r.upper) ?
                       -$signed({1'b0, quo_r[NumW-2:0], ~trial[NumW]}) :
                       $signed({1'b0, quo_r[NumW-2:0], ~trial[NumW]}));
              state_r <= S_EVAL;
            end
          end else begin
            rem_r <= trial[NumW] ? rem_sh : trial[NumW-1:0];
            quo_r <= {quo_r[NumW-2:0], ~trial[NumW]};
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_EVAL: begin
          if (pass && (!have_best_r || $signed(score_w[31:0]) > best_score_r)) begin
            best_score_r  <= score_w[31:0];
            best_bottom_r <= sat16(bx_r);
            best_top_r    <= sat16(tx_r);
            best_angle_r  <= it_r.theta;
            best_rho_r    <= it_r.rho;
            have_best_r   <= 1'b1;
          end
          state_r <= it_r.last ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid          <= 1'b1;
            out_lane_found     <= have_best_r;
            out_lane_bottom_x  <= best_bottom_r;
            out_lane_top_x     <= best_top_r;
            out_lane_theta_deg <= best_angle_r;
            out_lane_rho       <= best_rho_r;
            have_best_r   <= 1'b0;
            best_score_r  <= 32'sh80000000;
            best_bottom_r <= '0;
            best_top_r    <= '0;
            best_angle_r  <= '0;
            best_rho_r    <= '0;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/lane_line_selector.sv
// Top level of the lane line selector: configuration registers, front part,
// queue and back part. Depends on lls_pkg, lls_front, lls_queue and lls_back.
//
// Channel | Direction | Handshake
// in_     | input     | in_valid / in_stall
// out_    | output    | out_valid / out_stall
// cfg_    | input     | cfg_valid / cfg_ready
//
// A line in its half-plane goes through the back part in order: it is taken,
// runs two 40-step restoring divisions, one per crossing, and is scored. Any
// other line is only taken. After the last line of a frame the result is
// loaded, and it then holds while out_stall is high. A two-entry queue
// lets the front accept while the back is busy. Reset is synchronous.
`timescale 1ns / 1ps
module lane_line_selector
  import lls_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [11:0] in_line_rho,
  input  logic [7:0]         in_line_theta_deg,
  input  logic               in_last_line,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_lane_found,
  output logic signed [15:0] out_lane_bottom_x,
  output logic signed [15:0] out_lane_top_x,
  output logic [7:0]         out_lane_theta_deg,
  output logic signed [11:0] out_lane_rho,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  logic        side_mode_r;
  logic [11:0] top_row_r, bottom_row_r, left_bound_r, right_bound_r;
  logic        f_valid, q_valid, q_take;
  lls_item_t   f_item, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_mode_r   <= 1'b0;
      top_row_r     <= 12'd0;
      bottom_row_r  <= 12'd720;
      left_bound_r  <= 12'd0;
      right_bound_r <= 12'd1280;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegSideMode:   side_mode_r   <= cfg_data[0];
        RegTopRow:     top_row_r     <= cfg_data;
        RegBottomRow:  bottom_row_r  <= cfg_data;
        RegLeftBound:  left_bound_r  <= cfg_data;
        RegRightBound: right_bound_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lls_front u_front (
    .side_mode(side_mode_r), .in_valid, .in_line_rho,
    .in_line_theta_deg, .in_last_line, .item_valid(f_valid), .item(f_item)
  );

  lls_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_stall(in_stall), .wr_data(f_item),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
  );

  lls_back u_back (
    .clk, .rst_n, .side_mode(side_mode_r), .top_row(top_row_r),
    .bottom_row(bottom_row_r), .left_bound(left_bound_r),
    .right_bound(right_bound_r), .q_valid, .q_data, .q_take, .out_valid,
    .out_stall, .out_lane_found, .out_lane_bottom_x, .out_lane_top_x,
    .out_lane_theta_deg, .out_lane_rho
  );

endmodule

>>> rtl/lls_checker.sv
// Port checker for the lane line selector, bound to the top level.
// Depends on lane_line_selector_defines.svh.
`timescale 1ns / 1ps
`include "lane_line_selector_defines.svh"
module lls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_lane_found,
  input logic [15:0] out_lane_bottom_x,
  input logic [7:0]  out_lane_theta_deg
);

  `LLS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_lane_bottom_x))
  `LLS_ASSERT_IMP(a_empty_zero, out_valid && !out_lane_found, out_lane_theta_deg == 8'd0)
  `LLS_ASSERT_IMP(a_theta_range, out_valid, out_lane_theta_deg < 8'd180)
  `LLS_ASSERT_NXT(a_no_out_reset, !rst_n, !out_valid)

endmodule

bind lane_line_selector lls_checker u_lls_checker (
  .clk, .rst_n, .out_valid, .out_stall,
  .out_lane_found, .out_lane_bottom_x, .out_lane_theta_deg
);

>>> bench/lane_line_selector_tb.sv
// Self-checking testbench for lane_line_selector: directed and random Hough line
// frames, with a line-scoring predictor of its own. Depends on lls_pkg and the RTL.
`timescale 1ns / 1ps
module lane_line_selector_tb;
  import lls_pkg::*;

  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint unsigned OneQ30 = 64'd1073741824;
  localparam int              SettleCycles = 400;
  localparam int              WatchdogLimit = 20000;
  localparam logic [2:0]      RegUnused = 3'd5;

  typedef struct {
    logic               found;
    logic signed [15:0] bottom_x;
    logic signed [15:0] top_x;
    logic [7:0]         theta;
    logic signed [11:0] rho;
  } lane_result_t;

  typedef struct {
    logic signed [11:0] rho;
    logic [7:0]         theta;
    logic               last;
    logic               literal;
    lane_result_t       result;
  } line_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [11:0] in_line_rho = '0;
  logic [7:0] in_line_theta_deg = '0;
  logic in_last_line = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_lane_found;
  logic signed [15:0] out_lane_bottom_x;
  logic signed [15:0] out_lane_top_x;
  logic [7:0] out_lane_theta_deg;
  logic signed [11:0] out_lane_rho;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  lane_line_selector u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the registers and the frame state.
  logic        side_right;
  logic [11:0] row_top, row_bottom, bound_left, bound_right;
  longint      best_score;
  lane_result_t best_lane;
  logic        lane_held;

  lane_result_t lanes_due[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic void clear_frame();
    best_score = -64'sd2147483648;
    best_lane = '{1'b0, 16'sd0, 16'sd0, 8'd0, 12'sd0};
    lane_held = 1'b0;
  endfunction

  function automatic longint round_q14(longint unsigned v30);
    return longint'((v30 + 64'd32768) >> 16);
  endfunction

  // Taylor series in Q30, evaluated from the innermost term outwards.
  function automatic void trig_q14(input int unsigned tr, output longint s, output longint c);
    longint unsigned x, x2, r, t, den;
    x = (longint'(tr) * PiQ30 + 64'd90) / 64'd180;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    r = OneQ30;
    for (int i = 0; i < 6; i++) begin
      den = 64'(2 * (6 - i)) * 64'(2 * (6 - i) + 1);
      t = ((x2 * r) >> 30) / den;
      r = (t > OneQ30) ? 64'd0 : OneQ30 - t;
    end
    s = round_q14((x * r) >> 30);
    r = OneQ30;
    for (int i = 0; i < 7; i++) begin
      den = 64'(2 * (7 - i) - 1) * 64'(2 * (7 - i));
      t = ((x2 * r) >> 30) / den;
      r = (t > OneQ30) ? 64'd0 : OneQ30 - t;
    end
    c = round_q14(r);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic void score_line(input logic signed [11:0] rho, input logic [7:0] theta);
    int unsigned t, tr;
    bit upper, plane, pass;
    longint s, c, bx, tx, th8, score;
    longint unsigned th30;
    t = theta;
    upper = 2 * t > AngleSteps;
    plane = side_right ? (upper && t < AngleSteps) : (t > 0 && 2 * t < AngleSteps);
    if (plane) begin
      tr = upper ? AngleSteps - t : t;
      trig_q14(tr, s, c);
      if (upper) c = -c;
      if (c != 0) begin
        bx = (longint'(rho) * 16384 - longint'(row_bottom) * s) / c;
        tx = (longint'(rho) * 16384 - longint'(row_top) * s) / c;
        pass = bx < longint'(bound_right) && tx < longint'(bound_right)
               && bx > longint'(bound_left);
        if (side_right) pass = pass && tx > longint'(bound_left);
        if (pass) begin
          th30 = (longint'(t) * PiQ30 + 64'd90) / 64'd180;
          th8 = longint'((th30 + (64'd1 << 21)) >> 22);
          score = -10 * th8 - 2 * (longint'(bound_right) - bx) * 256;
          if (!lane_held || score > best_score) begin
            best_score = score;
            best_lane = '{1'b1, clamp16(bx), clamp16(tx), theta, rho};
            lane_held = 1'b1;
          end
        end
      end
    end
  endfunction

  task automatic send_line(input line_row_t row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_rho <= row.rho;
    in_line_theta_deg <= row.theta;
    in_last_line <= row.last;
    do @(posedge clk); while (in_stall);
    score_line(row.rho, row.theta);
    if (row.last) begin
      lanes_due.insert(lanes_due.size(), row.literal ? row.result : best_lane);
      clear_frame();
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegSideMode:   side_right = value[0];
      RegTopRow:     row_top = value;
      RegBottomRow:  row_bottom = value;
      RegLeftBound:  bound_left = value;
      RegRightBound: bound_right = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (lanes_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    lane_result_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end else if (out_valid && !out_stall) begin
        if (lanes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected lane item");
        end else begin
          want = lanes_due.pop_front();
          if (out_lane_found !== want.found || out_lane_bottom_x !== want.bottom_x ||
              out_lane_top_x !== want.top_x || out_lane_theta_deg !== want.theta ||
              out_lane_rho !== want.rho) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Lane mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                       want.found, want.bottom_x, want.top_x, want.theta, want.rho,
                       out_lane_found, out_lane_bottom_x, out_lane_top_x,
                       out_lane_theta_deg, out_lane_rho);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    lane_result_t none;
    line_row_t plan[$];
    line_row_t row;
    logic [11:0] conf[5];
    int frame_left;
    none = '{1'b0, 16'sd0, 16'sd0, 8'd0, 12'sd0};
    side_right = 1'b0;
    row_top = 12'd0;
    row_bottom = 12'd720;
    bound_left = 12'd0;
    bound_right = 12'd1280;
    clear_frame();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan = '{
      '{12'sd0, 8'd0, 1'b1, 1'b1, none},
      '{12'sd5, 8'd180, 1'b1, 1'b1, none},
      '{-12'sd5, 8'd255, 1'b1, 1'b1, none},
      '{12'sd300, 8'd90, 1'b1, 1'b1, none},
      '{12'sd2047, 8'd45, 1'b0, 1'b0, none},
      '{-12'sd2048, 8'd89, 1'b0, 1'b0, none},
      '{12'sd100, 8'd1, 1'b1, 1'b0, none},
      '{12'sd1000, 8'd30, 1'b0, 1'b0, none},
      '{12'sd1000, 8'd30, 1'b1, 1'b0, none},
      '{12'sd600, 8'd60, 1'b0, 1'b0, none},
      '{12'sd400, 8'd20, 1'b0, 1'b0, none},
      '{12'sd0, 8'd179, 1'b1, 1'b0, none},
      '{12'sd2047, 8'd1, 1'b0, 1'b0, none},
      '{12'sd500, 8'd45, 1'b1, 1'b0, none}
    };
    foreach (plan[i]) send_line(plan[i]);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: conf = '{12'd1, 12'd0, 12'd720, 12'd0, 12'd1280};
        1: conf = '{12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095};
        2: conf = '{12'd1, 12'd4095, 12'd4095, 12'd4095, 12'd0};
        3: conf = '{12'd1, 12'd200, 12'd700, 12'd100, 12'd1200};
        4: conf = '{12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095};
        5: conf = '{12'd1, 12'd0, 12'd0, 12'd0, 12'd4095};
        default: conf = '{12'($urandom_range(1)), 12'($urandom_range(4095)),
                          12'($urandom_range(4095)), 12'($urandom_range(1000)),
                          12'($urandom_range(600, 4095))};
      endcase
      write_reg(RegSideMode, conf[0]);
      write_reg(RegTopRow, conf[1]);
      write_reg(RegBottomRow, conf[2]);
      write_reg(RegLeftBound, conf[3]);
      write_reg(RegRightBound, conf[4]);
      write_reg(RegUnused, 12'($urandom));
      cfg_valid <= 1'b0;
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 71; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 71; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      frame_left = $urandom_range(1, 8);
      for (int n = 0; n < 225; n++) begin
        if (n == 110 && phase == 2) begin
          in_valid <= 1'b0;
          while (lanes_due.size() != 0) @(posedge clk);
        end
        frame_left--;
        row.rho = 12'($urandom);
        if ($urandom_range(99) < 60) row.rho = 12'(int'($urandom_range(1400)) - 300);
        row.theta = ($urandom_range(99) < 85) ? 8'($urandom_range(179))
                                               : 8'($urandom_range(255));
        row.last = (frame_left <= 0) || ($urandom_range(99) < 3);
        row.literal = 1'b0;
        row.result = none;
        send_line(row);
        if (row.last) frame_left = $urandom_range(1, 8);
      end
      if (frame_left < 8) begin
        row = '{12'($urandom), 8'($urandom_range(179)), 1'b1, 1'b0, none};
        send_line(row);
      end
      wait_drained();
    end

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
